### src/bpu_pkg.sv
// Shared types and constants of the BMP pixel unpacker.
// Used by every module of the block but bpu_ram; depends on nothing else.
package bpu_pkg;

  localparam int unsigned DimW       = 13;
  localparam int unsigned CoordW     = 12;
  localparam int unsigned RowByteW   = 15;
  localparam int unsigned ColorW     = 24;
  localparam int unsigned PixelW     = 32;
  localparam int unsigned PaletteSize = 256;
  localparam int unsigned PalIndexW  = $clog2(PaletteSize);

  localparam logic [DimW-1:0] MaxDim = 13'd4096;

  // Source depth codes; the unused fourth code behaves as 32-bit.
  localparam logic [1:0] DepthPal8  = 2'd0;
  localparam logic [1:0] DepthRgb24 = 2'd1;
  localparam logic [1:0] DepthXrgb32 = 2'd2;

  localparam logic ReqPalette = 1'b0;
  localparam logic ReqByte    = 1'b1;

  typedef enum logic [1:0] {
    RegDepthMode   = 2'd0,
    RegImageWidth  = 2'd1,
    RegImageHeight = 2'd2,
    RegTopDown     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]      depth_mode;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic            top_down;
  } cfg_t;

  typedef struct packed {
    logic              produce;
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic [PixelW-1:0] pixel;
    logic              last_pixel;
  } result_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > MaxDim) begin
      r = MaxDim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### src/bmp_pixel_unpacker.sv
// Top level of the BMP pixel unpacker: configuration registers, stage and
// output registers. Depends on bpu_pkg, bpu_palette and bpu_unpack.
//
// Usage: the input channel carries one beat per cycle unless stalled, either
// a palette write (req_type 0: pal_index, pal_color) or one byte of the pixel
// array in file order (req_type 1: data_byte). The output channel carries one
// beat per completed pixel: column, row (top row is 0), the 32-bit word and a
// flag on the final pixel of the image. Padding beats and palette writes give
// no output beat.
// An accepted beat passes the stage register, where the palette read lands,
// and then the output register. Throughput: one input beat per cycle while
// the input is not stalled, set by the single palette read port. The user
// must write the configuration registers only while the block is idle; the
// block itself does not enforce this. Reset clears all counters and marks
// every palette entry as black; no clearing sweep is needed. When the
// receiver stalls, the output beat holds and the input is stalled as soon as
// the stage register cannot move on.
module bmp_pixel_unpacker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [bpu_pkg::DimW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [bpu_pkg::PalIndexW-1:0] pal_index_i,
  input  logic [bpu_pkg::ColorW-1:0]   pal_color_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bpu_pkg::CoordW-1:0]   dest_x_o,
  output logic [bpu_pkg::CoordW-1:0]   dest_y_o,
  output logic [bpu_pkg::PixelW-1:0]   pixel_o,
  output logic                         last_pixel_o
);
  import bpu_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    s1_valid_q, s1_valid_d;
  logic    s1_req_q, s1_req_d;
  logic [7:0] s1_byte_q, s1_byte_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  result_t result;
  logic    in_accept, fire;
  logic [ColorW-1:0] pal_rd_color;

  assign fire       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegDepthMode:   cfg_d.depth_mode   = cfg_data_i[1:0];
        RegImageWidth:  cfg_d.image_width  = cfg_data_i;
        RegImageHeight: cfg_d.image_height = cfg_data_i;
        RegTopDown:     cfg_d.top_down     = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  bpu_palette u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_accept && (req_type_i == ReqPalette)),
    .wr_index_i (pal_index_i),
    .wr_color_i (pal_color_i),
    .rd_en_i    (in_accept && (req_type_i == ReqByte)),
    .rd_index_i (data_byte_i),
    .rd_color_o (pal_rd_color)
  );

  bpu_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fire_i      (fire),
    .req_type_i  (s1_req_q),
    .data_byte_i (s1_byte_q),
    .pal_color_i (pal_rd_color),
    .result_o    (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_req_d   = s1_req_q;
    s1_byte_d  = s1_byte_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
      s1_req_d   = req_type_i;
      s1_byte_d  = data_byte_i;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (fire && result.produce) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_mode   <= DepthPal8;
      cfg_q.image_width  <= DimW'(1);
      cfg_q.image_height <= DimW'(1);
      cfg_q.top_down     <= 1'b0;
      s1_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q  <= s1_req_d;
    s1_byte_q <= s1_byte_d;
    out_q     <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign dest_x_o     = out_q.dest_x;
  assign dest_y_o     = out_q.dest_y;
  assign pixel_o      = out_q.pixel;
  assign last_pixel_o = out_q.last_pixel;

endmodule

### src/bpu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package needed.
module bpu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/bpu_palette.sv
// Color palette: RAM plus one valid bit per entry so that reset reads as black.
// Depends on bpu_pkg and bpu_ram.
module bpu_palette (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [bpu_pkg::PalIndexW-1:0] wr_index_i,
  input  logic [bpu_pkg::ColorW-1:0]    wr_color_i,
  input  logic                          rd_en_i,
  input  logic [bpu_pkg::PalIndexW-1:0] rd_index_i,
  output logic [bpu_pkg::ColorW-1:0]    rd_color_o
);
  import bpu_pkg::*;

  logic [PaletteSize-1:0] valid_q, valid_d;
  logic                   rd_valid_q, rd_valid_d;
  logic [ColorW-1:0]      ram_rdata;

  bpu_ram #(
    .Width(ColorW),
    .Depth(PaletteSize)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_index_i),
    .wdata_i (wr_color_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_index_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (wr_en_i) begin
      valid_d[wr_index_i] = 1'b1;
    end
    rd_valid_d = rd_en_i ? valid_q[rd_index_i] : rd_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  assign rd_color_o = rd_valid_q ? ram_rdata : '0;

endmodule

### src/bpu_unpack.sv
// Row, column and byte counters plus pixel assembly for one beat per cycle while fire_i is high.
// Depends on bpu_pkg.
module bpu_unpack (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpu_pkg::cfg_t              cfg_i,
  input  logic                       fire_i,
  input  logic                       req_type_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [bpu_pkg::ColorW-1:0] pal_color_i,
  output bpu_pkg::result_t           result_o
);
  import bpu_pkg::*;

  logic [RowByteW-1:0] byte_in_row_q, byte_in_row_d;
  logic [1:0]          byte_in_pixel_q, byte_in_pixel_d;
  logic [ColorW-1:0]   assembly_q, assembly_d;
  logic [CoordW-1:0]   column_q, column_d;
  logic [DimW-1:0]     source_row_q, source_row_d;

  logic [DimW-1:0]     width_eff, height_eff, width_m1, height_m1, target_row;
  logic [2:0]          bpp;
  logic [RowByteW-1:0] data_bytes, row_round, row_size;
  logic [RowByteW:0]   row_next;
  logic [ColorW-1:0]   assembly_eff;
  logic                active, in_data, complete, last;
  logic [PixelW-1:0]   word;

  always_comb begin
    width_eff  = clamp_dim(cfg_i.image_width);
    height_eff = clamp_dim(cfg_i.image_height);
    width_m1   = width_eff - DimW'(1);
    height_m1  = height_eff - DimW'(1);

    case (cfg_i.depth_mode)
      DepthPal8: begin
        bpp        = 3'd1;
        data_bytes = RowByteW'(width_eff);
      end
      DepthRgb24: begin
        bpp        = 3'd3;
        data_bytes = RowByteW'(width_eff) + RowByteW'({width_eff, 1'b0});
      end
      default: begin
        bpp        = 3'd4;
        data_bytes = RowByteW'({width_eff, 2'b00});
      end
    endcase
    // Rows are padded up to a whole number of 32-bit words.
    row_round = data_bytes + RowByteW'(3);
    row_size  = {row_round[RowByteW-1:2], 2'b00};

    active       = source_row_q < height_eff;
    in_data      = byte_in_row_q < data_bytes;
    complete     = ({1'b0, byte_in_pixel_q} + 3'd1) >= bpp;
    assembly_eff = (byte_in_pixel_q == 2'd0) ? '0 : assembly_q;
    last         = (source_row_q == height_m1) && ({1'b0, column_q} >= width_m1);
    target_row   = cfg_i.top_down ? source_row_q : (height_m1 - source_row_q);
    row_next     = {1'b0, byte_in_row_q} + (RowByteW + 1)'(1);

    case (bpp)
      3'd1:    word = {8'h00, pal_color_i};
      3'd3:    word = {8'h00, assembly_eff} | {8'h00, data_byte_i, 16'h0000};
      default: word = {8'h00, assembly_eff} | {data_byte_i, 24'h000000};
    endcase
  end

  always_comb begin
    byte_in_row_d   = byte_in_row_q;
    byte_in_pixel_d = byte_in_pixel_q;
    assembly_d      = assembly_q;
    column_d        = column_q;
    source_row_d    = source_row_q;
    result_o.produce    = 1'b0;
    result_o.dest_x     = column_q;
    result_o.dest_y     = target_row[CoordW-1:0];
    result_o.pixel      = word;
    result_o.last_pixel = last;

    if (fire_i && (req_type_i == ReqByte) && active) begin
      if (in_data && complete) begin
        result_o.produce = 1'b1;
        byte_in_pixel_d  = 2'd0;
        assembly_d       = assembly_eff;
        column_d         = column_q + CoordW'(1);
      end else if (in_data) begin
        case (byte_in_pixel_q)
          2'd0:    assembly_d = assembly_eff | {16'h0000, data_byte_i};
          2'd1:    assembly_d = assembly_eff | {8'h00, data_byte_i, 8'h00};
          2'd2:    assembly_d = assembly_eff | {data_byte_i, 16'h0000};
          default: assembly_d = assembly_eff;
        endcase
        byte_in_pixel_d = byte_in_pixel_q + 2'd1;
      end

      if (in_data && complete && last) begin
        // The image is done; park the row counter so later beats are dropped.
        source_row_d  = height_eff;
        byte_in_row_d = '0;
        column_d      = '0;
      end else if (row_next >= {1'b0, row_size}) begin
        byte_in_row_d   = '0;
        byte_in_pixel_d = 2'd0;
        column_d        = '0;
        source_row_d    = source_row_q + DimW'(1);
      end else begin
        byte_in_row_d = row_next[RowByteW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_row_q   <= '0;
      byte_in_pixel_q <= '0;
      assembly_q      <= '0;
      column_q        <= '0;
      source_row_q    <= '0;
    end else begin
      byte_in_row_q   <= byte_in_row_d;
      byte_in_pixel_q <= byte_in_pixel_d;
      assembly_q      <= assembly_d;
      column_q        <= column_d;
      source_row_q    <= source_row_d;
    end
  end

endmodule

### src/bpu_checker.sv
// Port-level checks of the BMP pixel unpacker and the bind that attaches them.
// Depends on bpu_pkg and the top level bmp_pixel_unpacker.
module bpu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [bpu_pkg::CoordW-1:0]   dest_x_o,
  input logic [bpu_pkg::CoordW-1:0]   dest_y_o,
  input logic [bpu_pkg::PixelW-1:0]   pixel_o,
  input logic                         last_pixel_o
);

  // A stalled output beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(dest_x_o) && $stable(dest_y_o) && $stable(pixel_o) && $stable(last_pixel_o))
    else $error("output payload changed while stalled");

  // With the output register empty, the stage always drains, so input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output register");

  // Input back-pressure only comes from a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the receiver is ready");

endmodule

bind bmp_pixel_unpacker bpu_checker u_bpu_checker (.*);
